### design/gou_pkg.sv
// Shared types, sizes and helpers for the grid overlay upscaler.
`default_nettype none

package gou_pkg;

  // Largest source row held in the line store, and largest zoom per axis.
  localparam int MAX_WIDTH = 1024;
  localparam int MAX_SCALE = 64;
  localparam int SRC_H_LIMIT = 1024;

  // Register widths, fixed by the register map.
  localparam int SRC_SIZE_W = 11;
  localparam int DST_SIZE_W = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_INDEX_W = 2;

  // Derived widths.
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(SRC_H_LIMIT);
  localparam int SCALE_SHIFT = $clog2(MAX_SCALE);
  localparam int RUN_W = SCALE_SHIFT + 1;
  localparam int DIV_STEPS = SCALE_SHIFT + 1;
  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam int REM_W = SRC_SIZE_W + SCALE_SHIFT + 1;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_WIDTH = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

  // Fault codes.
  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_KIND = 2'd1;
  localparam logic [1:0] FAULT_SIZE = 2'd2;

  // Item kinds.
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_REPLAY = 1'b1;

  // Grid blend weights.
  localparam int GRID_GRAY = 128;
  localparam int PIXEL_WEIGHT = 156;
  localparam int GRID_WEIGHT = 100;
  localparam int BLEND_SHIFT = 8;

  typedef struct packed {
    logic       func;
    logic [7:0] gray_in;
  } src_word_t;

  typedef struct packed {
    logic [7:0] gray_out;
    logic       on_grid;
    logic       run_last;
    logic       row_end;
    logic       frame_end;
    logic [1:0] fault;
  } dst_word_t;

  // (p*156 + 128*100) >> 8, always below 256
  function automatic logic [7:0] grid_blend(input logic [7:0] p);
    logic [16:0] acc;
    acc = 17'(p) * 17'(PIXEL_WEIGHT) + 17'(GRID_GRAY * GRID_WEIGHT);
    return acc[BLEND_SHIFT +: 8];
  endfunction

endpackage

`default_nettype wire

### design/grid_overlay_upscaler.sv
// Nearest-neighbor upscaler with grid overlay: top level.
//
// Source words (func, gray_in) enter on src_valid/src_ready; destination
// pixels leave on dst_valid/dst_ready, one word per destination pixel, in
// row-major order. func=0 words carry source pixels of the first row of a
// band; func=1 words replay the line store for the remaining rows.
// Each accepted word is registered, then a restoring divider works out the
// column run and the band height from the remainder accumulators (one
// quotient bit per cycle), then the results leave one per cycle while the
// receiver keeps up. The output register frees the block to take the next
// word while the last result still waits. A fault word (bad sizes or wrong
// kind) gives one result. The line store is a 1024 x 8 synchronous RAM,
// written by func=0 words and read at accept by func=1 words; a word is
// finished before the next one enters, so reads never race writes.
// A receiver stall simply holds the output register and pauses emission.
// Reset (synchronous, active high) sets all sizes to 1 and puts the
// position at the start of a frame; the line store is not cleared. Any
// register write also restarts the frame.
`default_nettype none

module grid_overlay_upscaler (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  src_valid,
  output logic                                  src_ready,
  input  gou_pkg::src_word_t                    src_word,
  output logic                                  dst_valid,
  input  logic                                  dst_ready,
  output gou_pkg::dst_word_t                    dst_word,
  input  logic                                  cfg_write_en,
  input  logic [gou_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [gou_pkg::CFG_DATA_W-1:0]        cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT, S_FAULT} state_t;

  state_t state;

  // size registers
  logic [gou_pkg::SRC_SIZE_W-1:0] source_width;
  logic [gou_pkg::SRC_SIZE_W-1:0] source_height;
  logic [gou_pkg::DST_SIZE_W-1:0] target_width;
  logic [gou_pkg::DST_SIZE_W-1:0] target_height;

  // frame position
  logic [gou_pkg::COL_W-1:0]   column_count;
  logic [gou_pkg::ROW_W-1:0]   row_count;
  logic [gou_pkg::RUN_W-2:0]   band_row;
  logic [gou_pkg::COL_W-1:0]   column_accum;
  logic [gou_pkg::ROW_W-1:0]   row_accum;
  logic                        replay_mode;

  // current word
  logic                        func_r;
  logic [7:0]                  gray_r;
  logic [1:0]                  fault_r;

  // divider
  logic [gou_pkg::REM_W-1:0]   crem, rrem, cdiv, rdiv;
  logic [gou_pkg::RUN_W-1:0]   cq, rq;
  logic [gou_pkg::STEP_W-1:0]  step;
  logic [gou_pkg::RUN_W-1:0]   left;

  // line store
  logic [7:0] line_store [gou_pkg::MAX_WIDTH];
  logic [7:0] mem_q;
  logic       mem_we, mem_re;

  logic                        accept;
  logic                        sizes_ok;
  logic [1:0]                  item_fault;
  logic [gou_pkg::REM_W-1:0]   wide_sw, wide_sh;
  logic                        c_ge, r_ge;
  logic [gou_pkg::REM_W-1:0]   crem_sub, rrem_sub;
  logic [gou_pkg::RUN_W-1:0]   cq_next, rq_next;
  logic [7:0]                  pixel;
  logic                        grid_row, last_run, on_grid_v, last_col, last_src_row;
  logic                        row_end_v;
  logic                        out_free;

  // ---- size check -------------------------------------------------------
  assign wide_sw = gou_pkg::REM_W'(source_width) << gou_pkg::SCALE_SHIFT;
  assign wide_sh = gou_pkg::REM_W'(source_height) << gou_pkg::SCALE_SHIFT;

  assign sizes_ok =
      (source_width != '0) &&
      (source_width <= gou_pkg::SRC_SIZE_W'(gou_pkg::MAX_WIDTH)) &&
      (source_height != '0) &&
      (source_height <= gou_pkg::SRC_SIZE_W'(gou_pkg::SRC_H_LIMIT)) &&
      (gou_pkg::REM_W'(target_width) >= gou_pkg::REM_W'(source_width)) &&
      (gou_pkg::REM_W'(target_width) <= wide_sw) &&
      (gou_pkg::REM_W'(target_height) >= gou_pkg::REM_W'(source_height)) &&
      (gou_pkg::REM_W'(target_height) <= wide_sh);

  // no word is taken while reset is held
  assign src_ready = (state == S_IDLE) && !rst;
  assign accept = src_valid && src_ready;

  always_comb begin
    priority if (!sizes_ok) begin
      item_fault = gou_pkg::FAULT_SIZE;
    end else if (src_word.func != replay_mode) begin
      item_fault = gou_pkg::FAULT_KIND;
    end else begin
      item_fault = gou_pkg::FAULT_NONE;
    end
  end

  // ---- line store -------------------------------------------------------
  assign mem_we = accept && (item_fault == gou_pkg::FAULT_NONE) &&
                  (src_word.func == gou_pkg::FUNC_PIXEL);
  assign mem_re = accept && (item_fault == gou_pkg::FAULT_NONE) &&
                  (src_word.func == gou_pkg::FUNC_REPLAY);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[column_count] <= src_word.gray_in;
    end
    if (mem_re) begin
      mem_q <= line_store[column_count];
    end
  end

  // ---- divider step: one quotient bit per cycle for both axes -----------
  assign c_ge = (crem >= cdiv);
  assign r_ge = (rrem >= rdiv);
  assign crem_sub = crem - cdiv;
  assign rrem_sub = rrem - rdiv;
  assign cq_next = {cq[gou_pkg::RUN_W-2:0], c_ge};
  assign rq_next = {rq[gou_pkg::RUN_W-2:0], r_ge};

  // ---- emission ---------------------------------------------------------
  assign pixel = (func_r == gou_pkg::FUNC_REPLAY) ? mem_q : gray_r;
  // rq holds the band height in destination rows
  assign grid_row = (gou_pkg::RUN_W'(band_row) + gou_pkg::RUN_W'(1)) >= rq;
  assign last_run = (left == gou_pkg::RUN_W'(1));
  assign on_grid_v = grid_row || last_run;
  assign last_col = (gou_pkg::SRC_SIZE_W'(column_count) + gou_pkg::SRC_SIZE_W'(1))
                    == source_width;
  assign last_src_row = (gou_pkg::SRC_SIZE_W'(row_count) + gou_pkg::SRC_SIZE_W'(1))
                        >= source_height;
  assign row_end_v = last_run && last_col;
  assign out_free = !dst_valid || dst_ready;

  // ---- control ----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      dst_valid     <= 1'b0;
      source_width  <= gou_pkg::SRC_SIZE_W'(1);
      source_height <= gou_pkg::SRC_SIZE_W'(1);
      target_width  <= gou_pkg::DST_SIZE_W'(1);
      target_height <= gou_pkg::DST_SIZE_W'(1);
      column_count  <= '0;
      row_count     <= '0;
      band_row      <= '0;
      column_accum  <= '0;
      row_accum     <= '0;
      replay_mode   <= 1'b0;
      step          <= '0;
      left          <= '0;
    end else begin
      if (dst_valid && dst_ready) begin
        dst_valid <= 1'b0;
      end

      // register writes must arrive only while idle, which the block does not enforce; each restarts the frame
      if (cfg_write_en) begin
        unique case (cfg_index)
          gou_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data[gou_pkg::SRC_SIZE_W-1:0];
          gou_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data[gou_pkg::SRC_SIZE_W-1:0];
          gou_pkg::REG_TARGET_WIDTH:  target_width  <= cfg_data[gou_pkg::DST_SIZE_W-1:0];
          gou_pkg::REG_TARGET_HEIGHT: target_height <= cfg_data[gou_pkg::DST_SIZE_W-1:0];
        endcase
        column_count <= '0;
        row_count    <= '0;
        band_row     <= '0;
        column_accum <= '0;
        row_accum    <= '0;
        replay_mode  <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            func_r  <= src_word.func;
            gray_r  <= src_word.gray_in;
            fault_r <= item_fault;
            if (item_fault != gou_pkg::FAULT_NONE) begin
              state <= S_FAULT;
            end else begin
              crem  <= gou_pkg::REM_W'(column_accum) + gou_pkg::REM_W'(target_width);
              rrem  <= gou_pkg::REM_W'(row_accum) + gou_pkg::REM_W'(target_height);
              cdiv  <= wide_sw;
              rdiv  <= wide_sh;
              cq    <= '0;
              rq    <= '0;
              step  <= '0;
              state <= S_DIV;
            end
          end
        end

        S_DIV: begin
          if (c_ge) begin
            crem <= crem_sub;
          end
          if (r_ge) begin
            rrem <= rrem_sub;
          end
          cq   <= cq_next;
          rq   <= rq_next;
          cdiv <= cdiv >> 1;
          rdiv <= rdiv >> 1;
          step <= step + gou_pkg::STEP_W'(1);
          if (step == gou_pkg::STEP_W'(gou_pkg::DIV_STEPS - 1)) begin
            left  <= cq_next;   // run length, at least one
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            dst_valid          <= 1'b1;
            dst_word.gray_out  <= on_grid_v ? gou_pkg::grid_blend(pixel) : pixel;
            dst_word.on_grid   <= on_grid_v;
            dst_word.run_last  <= last_run;
            dst_word.row_end   <= row_end_v;
            dst_word.frame_end <= row_end_v && grid_row && last_src_row;
            dst_word.fault     <= gou_pkg::FAULT_NONE;
            left               <= left - gou_pkg::RUN_W'(1);
            if (last_run) begin
              state <= S_IDLE;
              // advance the frame position; crem/rrem now hold remainders
              if (!last_col) begin
                column_count <= column_count + gou_pkg::COL_W'(1);
                column_accum <= crem[gou_pkg::COL_W-1:0];
              end else begin
                column_count <= '0;
                column_accum <= '0;
                if (!grid_row) begin
                  band_row    <= band_row + (gou_pkg::RUN_W-1)'(1);
                  replay_mode <= 1'b1;
                end else begin
                  band_row    <= '0;
                  replay_mode <= 1'b0;
                  if (last_src_row) begin
                    row_count <= '0;
                    row_accum <= '0;
                  end else begin
                    row_count <= row_count + gou_pkg::ROW_W'(1);
                    row_accum <= rrem[gou_pkg::ROW_W-1:0];
                  end
                end
              end
            end
          end
        end

        S_FAULT: begin
          if (out_free) begin
            dst_valid          <= 1'b1;
            dst_word.gray_out  <= '0;
            dst_word.on_grid   <= 1'b0;
            dst_word.run_last  <= 1'b1;
            dst_word.row_end   <= 1'b0;
            dst_word.frame_end <= 1'b0;
            dst_word.fault     <= fault_r;
            state              <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/tb_grid_overlay_upscaler.sv
// Self-checking testbench for grid_overlay_upscaler: directed and random frames against a scaler model.
`timescale 1ns / 100ps

module tb_grid_overlay_upscaler;

  // Timeout bound, in clock cycles. It is far above the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  // Source words in the random part.
  localparam int unsigned RANDOM_ITEMS = 370;
  // Cycles allowed after the last result before a register write or the end.
  localparam int unsigned SETTLE_CYCLES = 12;

  logic clk;
  logic rst;
  logic src_valid;
  logic src_ready;
  gou_pkg::src_word_t src_word;
  logic dst_valid;
  logic dst_ready;
  gou_pkg::dst_word_t dst_word;
  logic cfg_write_en;
  logic [gou_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [gou_pkg::CFG_DATA_W-1:0] cfg_data;

  grid_overlay_upscaler DUT (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_word(src_word),
    .dst_valid(dst_valid),
    .dst_ready(dst_ready),
    .dst_word(dst_word),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Destination pixels still owed by the block, oldest first.
  gou_pkg::dst_word_t expected_pixels[$];
  gou_pkg::dst_word_t want_word;
  bit failed;
  bit idle_on;
  int unsigned cycle_count;
  int unsigned stall_left;

  // Scaler model: size registers as the block holds them, plus its position.
  logic [gou_pkg::SRC_SIZE_W-1:0] cur_sw;
  logic [gou_pkg::SRC_SIZE_W-1:0] cur_sh;
  logic [gou_pkg::DST_SIZE_W-1:0] cur_tw;
  logic [gou_pkg::DST_SIZE_W-1:0] cur_th;
  logic [7:0] line_copy [gou_pkg::MAX_WIDTH];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned band_pos;
  int unsigned col_rem;
  int unsigned row_rem;
  bit replay_due;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** grid_overlay_upscaler: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Scaler model
  // ---------------------------------------------------------------------

  function automatic logic [7:0] grid_tone(input logic [7:0] p);
    int unsigned mix;
    mix = (int'(p) * gou_pkg::PIXEL_WEIGHT + gou_pkg::GRID_GRAY * gou_pkg::GRID_WEIGHT)
          >> gou_pkg::BLEND_SHIFT;
    return mix[7:0];
  endfunction

  function automatic gou_pkg::dst_word_t pixel_word(input logic [7:0] g, input logic grid,
                                                    input logic last, input logic rend,
                                                    input logic fend,
                                                    input logic [1:0] flt);
    gou_pkg::dst_word_t w;
    w.gray_out = g;
    w.on_grid = grid;
    w.run_last = last;
    w.row_end = rend;
    w.frame_end = fend;
    w.fault = flt;
    return w;
  endfunction

  function automatic bit sizes_valid();
    int unsigned sw, sh, tw, th;
    sw = cur_sw;
    sh = cur_sh;
    tw = cur_tw;
    th = cur_th;
    return sw >= 1 && sw <= gou_pkg::MAX_WIDTH && sh >= 1 && sh <= gou_pkg::SRC_H_LIMIT &&
           tw >= sw && tw <= gou_pkg::MAX_SCALE * sw &&
           th >= sh && th <= gou_pkg::MAX_SCALE * sh;
  endfunction

  task automatic restart_position();
    col_pos = 0;
    row_pos = 0;
    band_pos = 0;
    col_rem = 0;
    row_rem = 0;
    replay_due = 1'b0;
  endtask

  // Works out every destination pixel caused by one accepted source word.
  task automatic upscale_word(input gou_pkg::src_word_t w);
    int unsigned pix, rsum, csum, band_rows, run;
    logic grid_row, last_col, last_src_row, last, grid;
    if (!sizes_valid()) begin
      expected_pixels.push_back(pixel_word(8'd0, 1'b0, 1'b1, 1'b0, 1'b0,
                                           gou_pkg::FAULT_SIZE));
    end else if ((w.func == gou_pkg::FUNC_REPLAY) != replay_due) begin
      expected_pixels.push_back(pixel_word(8'd0, 1'b0, 1'b1, 1'b0, 1'b0,
                                           gou_pkg::FAULT_KIND));
    end else begin
      if (col_pos >= cur_sw || col_pos >= gou_pkg::MAX_WIDTH) restart_position();
      if (w.func == gou_pkg::FUNC_PIXEL) line_copy[col_pos] = w.gray_in;
      pix = line_copy[col_pos];
      rsum = row_rem + cur_th;
      band_rows = rsum / cur_sh;
      csum = col_rem + cur_tw;
      run = csum / cur_sw;
      if (run > gou_pkg::MAX_SCALE) run = gou_pkg::MAX_SCALE;
      // the last row of a band is a grid row
      grid_row = (band_pos + 1 >= band_rows);
      last_col = (col_pos + 1 == cur_sw);
      last_src_row = (row_pos + 1 >= cur_sh);
      for (int unsigned i = 0; i < run; i++) begin
        last = (i + 1 == run);
        grid = grid_row || last;
        expected_pixels.push_back(pixel_word(grid ? grid_tone(pix[7:0]) : pix[7:0], grid,
                                             last, last && last_col,
                                             last && last_col && grid_row && last_src_row,
                                             gou_pkg::FAULT_NONE));
      end
      col_rem = csum % cur_sw;
      col_pos++;
      if (last_col) begin
        col_pos = 0;
        col_rem = 0;
        if (!grid_row) begin
          band_pos++;
          replay_due = 1'b1;
        end else begin
          band_pos = 0;
          replay_due = 1'b0;
          if (last_src_row) begin
            restart_position();
          end else begin
            row_pos++;
            row_rem = rsum % cur_sh;
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Receiver side: random stall stretches while idling is on.
  initial begin
    dst_ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && idle_on && $urandom_range(99) < 20) stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        dst_ready <= 1'b0;
      end else begin
        dst_ready <= 1'b1;
      end
    end
  end

  // Sends one source word. Valid is left high after the accept so that a
  // back-to-back word needs no drop; a gap or drain() lowers it.
  task automatic send_word(input logic func, input logic [7:0] gray);
    int unsigned gap;
    gou_pkg::src_word_t w;
    w.func = func;
    w.gray_in = gray;
    gap = pick_gap();
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_word <= w;
    do @(posedge clk); while (!src_ready);
    upscale_word(w);
  endtask

  // Follows the expected kind of word, flipping it now and then.
  task automatic stream_items(input int unsigned count, input int unsigned noise_pct);
    logic func;
    repeat (count) begin
      func = replay_due ? gou_pkg::FUNC_REPLAY : gou_pkg::FUNC_PIXEL;
      if ($urandom_range(99) < noise_pct) func = ~func;
      send_word(func, 8'($urandom_range(255)));
    end
  endtask

  // Waits until every owed pixel has come out and the block is idle.
  task automatic drain();
    src_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gou_pkg::CFG_INDEX_W-1:0] idx,
                           input int unsigned value);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[gou_pkg::CFG_DATA_W-1:0];
    case (idx)
      gou_pkg::REG_SOURCE_WIDTH: cur_sw = value[gou_pkg::SRC_SIZE_W-1:0];
      gou_pkg::REG_SOURCE_HEIGHT: cur_sh = value[gou_pkg::SRC_SIZE_W-1:0];
      gou_pkg::REG_TARGET_WIDTH: cur_tw = value[gou_pkg::DST_SIZE_W-1:0];
      gou_pkg::REG_TARGET_HEIGHT: cur_th = value[gou_pkg::DST_SIZE_W-1:0];
      default: ;
    endcase
    // any write puts the block back at the start of a frame
    restart_position();
  endtask

  task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                           input int unsigned tw, input int unsigned th);
    drain();
    write_reg(gou_pkg::REG_SOURCE_WIDTH, sw);
    write_reg(gou_pkg::REG_SOURCE_HEIGHT, sh);
    write_reg(gou_pkg::REG_TARGET_WIDTH, tw);
    write_reg(gou_pkg::REG_TARGET_HEIGHT, th);
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Output checking
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && dst_valid && dst_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected output word %h", dst_word);
        failed = 1'b1;
      end else begin
        want_word = expected_pixels.pop_front();
        if (dst_word.gray_out !== want_word.gray_out) begin
          $error("gray_out: expected %0d, got %0d", want_word.gray_out, dst_word.gray_out);
          failed = 1'b1;
        end
        if (dst_word.on_grid !== want_word.on_grid) begin
          $error("on_grid: expected %0d, got %0d", want_word.on_grid, dst_word.on_grid);
          failed = 1'b1;
        end
        if (dst_word.run_last !== want_word.run_last) begin
          $error("run_last: expected %0d, got %0d", want_word.run_last, dst_word.run_last);
          failed = 1'b1;
        end
        if (dst_word.row_end !== want_word.row_end) begin
          $error("row_end: expected %0d, got %0d", want_word.row_end, dst_word.row_end);
          failed = 1'b1;
        end
        if (dst_word.frame_end !== want_word.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want_word.frame_end,
                 dst_word.frame_end);
          failed = 1'b1;
        end
        if (dst_word.fault !== want_word.fault) begin
          $error("fault: expected %0d, got %0d", want_word.fault, dst_word.fault);
          failed = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // All sizes are 1 out of reset: each pixel is a one-pixel grid frame, a replay word a kind fault.
  task automatic test_reset_defaults();
    send_word(gou_pkg::FUNC_PIXEL, 8'h00);
    send_word(gou_pkg::FUNC_PIXEL, 8'hFF);
    send_word(gou_pkg::FUNC_REPLAY, 8'h3C);
  endtask

  // Out-of-range sizes of each kind but a target height below the source height; each gives a size fault.
  task automatic test_bad_sizes();
    set_sizes(0, 1, 1, 1);
    send_word(gou_pkg::FUNC_PIXEL, 8'h5A);
    set_sizes(1025, 1, 1025, 1);
    send_word(gou_pkg::FUNC_REPLAY, 8'hA5);
    set_sizes(4, 0, 4, 1);
    send_word(gou_pkg::FUNC_PIXEL, 8'h11);
    set_sizes(4, 2, 3, 2);
    send_word(gou_pkg::FUNC_PIXEL, 8'h22);
    set_sizes(4, 2, 257, 2);
    send_word(gou_pkg::FUNC_PIXEL, 8'h33);
    set_sizes(4, 2, 4, 129);
    send_word(gou_pkg::FUNC_REPLAY, 8'h44);
    set_sizes(2047, 2047, 131071, 131071);
    send_word(gou_pkg::FUNC_PIXEL, 8'h55);
  endtask

  // Widest row and largest zoom; frames are left unfinished on purpose,
  // the next register write restarts them.
  task automatic test_extremes();
    set_sizes(gou_pkg::MAX_WIDTH, 1, gou_pkg::MAX_SCALE * gou_pkg::MAX_WIDTH, 1);
    send_word(gou_pkg::FUNC_PIXEL, 8'hFF);
    send_word(gou_pkg::FUNC_PIXEL, 8'h00);
    set_sizes(gou_pkg::MAX_WIDTH, gou_pkg::SRC_H_LIMIT, gou_pkg::MAX_WIDTH,
              gou_pkg::SRC_H_LIMIT);
    send_word(gou_pkg::FUNC_PIXEL, 8'h80);
    send_word(gou_pkg::FUNC_PIXEL, 8'h7F);
    // 64-row band from one pixel: replays, then a stray pixel (kind fault)
    set_sizes(1, gou_pkg::SRC_H_LIMIT, gou_pkg::MAX_SCALE,
              gou_pkg::MAX_SCALE * gou_pkg::SRC_H_LIMIT);
    send_word(gou_pkg::FUNC_PIXEL, 8'hC3);
    send_word(gou_pkg::FUNC_REPLAY, 8'h00);
    send_word(gou_pkg::FUNC_REPLAY, 8'hFF);
    send_word(gou_pkg::FUNC_PIXEL, 8'h96);
  endtask

  // A kind fault, then a whole 2x2 -> 3x3 frame (uneven bands), then into the next frame.
  task automatic test_frame_walk();
    set_sizes(2, 2, 3, 3);
    send_word(gou_pkg::FUNC_REPLAY, 8'h01);
    stream_items(7, 0);
  endtask

  function automatic int unsigned zoom_of(input int unsigned n);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(n, 3 * n);
    if (roll < 90) return $urandom_range(3 * n, 8 * n);
    return $urandom_range(8 * n, gou_pkg::MAX_SCALE * n);
  endfunction

  task automatic test_random_frames();
    int unsigned sent, batch, phase, sw, sh, tw, th;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = (phase % 4 != 3);
      if ($urandom_range(9) == 0) begin
        // one of the out-of-range cases, with a short burst of words
        sw = $urandom_range(1, 8);
        sh = $urandom_range(1, 4);
        tw = 2 * sw;
        th = 2 * sh;
        case ($urandom_range(5))
          0: sw = 0;
          1: sw = $urandom_range(gou_pkg::MAX_WIDTH + 1, 2047);
          2: sh = ($urandom_range(1) == 0) ? 0 :
                  $urandom_range(gou_pkg::SRC_H_LIMIT + 1, 2047);
          3: begin
            sw = $urandom_range(2, 8);
            tw = $urandom_range(1, sw - 1);
          end
          4: tw = $urandom_range(gou_pkg::MAX_SCALE * sw + 1, 131071);
          default: th = $urandom_range(gou_pkg::MAX_SCALE * sh + 1, 131071);
        endcase
        batch = $urandom_range(4, 10);
      end else begin
        sw = ($urandom_range(99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        sh = ($urandom_range(99) < 80) ? $urandom_range(1, 4) : $urandom_range(5, 12);
        tw = zoom_of(sw);
        th = zoom_of(sh);
        batch = $urandom_range(20, 60);
      end
      set_sizes(sw, sh, tw, th);
      stream_items(batch, 6);
      sent += batch;
      phase++;
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    rst <= 1'b1;
    src_valid <= 1'b0;
    src_word <= '0;
    cfg_write_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    failed = 1'b0;
    idle_on = 1'b1;
    cycle_count = 0;
    cur_sw = 1;
    cur_sh = 1;
    cur_tw = 1;
    cur_th = 1;
    restart_position();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_bad_sizes();
    test_extremes();
    test_frame_walk();
    test_random_frames();

    // drain() leaves room for the block's own latency after the last pixel
    drain();
    if (!failed) begin
      $display("** grid_overlay_upscaler: PASSED **");
    end else begin
      $display("** grid_overlay_upscaler: FAILED **");
    end
    $finish;
  end

endmodule
